// ===== hw/rtl/lsra_pkg.sv =====
// Shared types and constants for the linear scan register allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lsra_pkg;

	localparam int POS_W = 16;
	localparam logic [15:0] SLOT_STEP = 16'd4;

	// register pool size; reg_num in res_t is sized for it
	localparam int POOL_REGS = 8;
	localparam int IDX_W     = (POOL_REGS > 1) ? $clog2(POOL_REGS) : 1;
	localparam int CNT_W     = $clog2(POOL_REGS + 1);

	localparam logic [1:0] KIND_ASSIGN = 2'd0;
	localparam logic [1:0] KIND_SPILL  = 2'd1;
	localparam logic [1:0] KIND_EVICT  = 2'd2;

	typedef struct packed {
		logic [9:0]       interval_id;
		logic [POS_W-1:0] interval_start;
		logic [POS_W-1:0] interval_end;
		logic             restart;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  target_id;
		logic [2:0]  reg_num;
		logic [15:0] slot_offset;
		logic        last;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic expire;
		logic decide;
		logic insert;
		logic emit0;
		logic emit1;
	} lsra_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic expire_hit;
		logic decide_ins;
		logic two_res;
		logic out_free;
	} lsra_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsra_ctrl.sv =====
// Sequencer for the allocator: expiry loop, decision, insertion, result emit.
// Depends on lsra_pkg for the command and status structs.
`default_nettype none

module lsra_ctrl import lsra_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire lsra_stat_t stat,
	output lsra_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXPIRE,
		S_DECIDE,
		S_INSERT,
		S_EMIT0,
		S_EMIT1
	} state_t;

	state_t state_q;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && req_valid;
		cmd.expire = (state_q == S_EXPIRE) && stat.expire_hit;
		cmd.decide = (state_q == S_DECIDE);
		cmd.insert = (state_q == S_INSERT);
		cmd.emit0  = (state_q == S_EMIT0) && stat.out_free;
		cmd.emit1  = (state_q == S_EMIT1) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EXPIRE;
				end
				S_EXPIRE: begin
					if (!stat.expire_hit) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= stat.decide_ins ? S_INSERT : S_EMIT0;
				end
				S_INSERT: begin
					state_q <= S_EMIT0;
				end
				S_EMIT0: begin
					if (stat.out_free) state_q <= stat.two_res ? S_EMIT1 : S_IDLE;
				end
				S_EMIT1: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lsra_dp.sv =====
// Datapath: sorted active list, LIFO free stack, slot counter, result register.
// Depends on lsra_pkg; driven by lsra_ctrl commands.
`default_nettype none

module lsra_dp import lsra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [3:0]  max_active,
	input  wire logic [15:0] stack_base,
	input  wire req_t        req_data,
	input  wire lsra_cmd_t   cmd,
	output lsra_stat_t       stat,
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res_data
);

	// active list, kept sorted by increasing end; entries below acnt_q are live
	logic [POS_W-1:0] end_q  [POOL_REGS];
	logic [9:0]       tag_q  [POOL_REGS];
	logic [IDX_W-1:0] areg_q [POOL_REGS];
	logic [CNT_W-1:0] acnt_q;

	logic [IDX_W-1:0] fstk_q [POOL_REGS];
	logic [CNT_W-1:0] fcnt_q;
	logic [15:0]      slot_q;

	req_t             cur_q;
	res_t             res0_q, res1_q;
	logic             two_q;
	logic [IDX_W-1:0] ins_reg_q;
	logic             res_valid_q;
	res_t             res_data_q;

	logic [7:0]       lim;
	logic             spill, evict, expire_hit;
	logic [IDX_W-1:0] last_idx, top_idx;
	logic             keep [POOL_REGS];

	assign last_idx   = IDX_W'(acnt_q - 1'b1);
	assign top_idx    = IDX_W'(fcnt_q - 1'b1);
	assign expire_hit = (acnt_q != '0) && (end_q[0] < cur_q.interval_start);

	always_comb begin
		priority if (max_active == 4'd0) begin
			lim = 8'd1;
		end else if (8'(max_active) > 8'(POOL_REGS)) begin
			lim = 8'(POOL_REGS);
		end else begin
			lim = 8'(max_active);
		end
	end

	assign spill = (8'(acnt_q) >= lim) || (fcnt_q == '0);
	assign evict = spill && (acnt_q != '0) && (end_q[last_idx] > cur_q.interval_end);

	always_comb begin
		for (int i = 0; i < POOL_REGS; i++) begin
			keep[i] = (CNT_W'(i) < acnt_q) && (end_q[i] <= cur_q.interval_end);
		end
	end

	always_comb begin
		stat.expire_hit = expire_hit;
		stat.decide_ins = !spill || evict;
		stat.two_res    = two_q;
		stat.out_free   = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acnt_q      <= '0;
			fcnt_q      <= CNT_W'(POOL_REGS);
			slot_q      <= '0;
			res_valid_q <= 1'b0;
			two_q       <= 1'b0;
			for (int i = 0; i < POOL_REGS; i++) fstk_q[i] <= IDX_W'(i);
		end else begin
			if (cmd.accept && req_data.restart) begin
				acnt_q <= '0;
				fcnt_q <= CNT_W'(POOL_REGS);
				slot_q <= stack_base;
				for (int i = 0; i < POOL_REGS; i++) fstk_q[i] <= IDX_W'(i);
			end
			if (cmd.expire) begin
				acnt_q <= acnt_q - 1'b1;
				if (fcnt_q < CNT_W'(POOL_REGS)) begin
					fstk_q[IDX_W'(fcnt_q)] <= areg_q[0];
					fcnt_q <= fcnt_q + 1'b1;
				end
			end
			if (cmd.decide) begin
				two_q <= evict;
				if (spill) begin
					slot_q <= slot_q + SLOT_STEP;
					// victim leaves the list; the new request is inserted next cycle
					if (evict) acnt_q <= acnt_q - 1'b1;
				end else begin
					fcnt_q <= fcnt_q - 1'b1;
				end
			end
			if (cmd.insert) acnt_q <= acnt_q + 1'b1;
			if (cmd.emit0 || cmd.emit1) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) cur_q <= req_data;
		if (cmd.expire) begin
			for (int i = 0; i < POOL_REGS - 1; i++) begin
				end_q[i]  <= end_q[i+1];
				tag_q[i]  <= tag_q[i+1];
				areg_q[i] <= areg_q[i+1];
			end
		end
		if (cmd.decide) begin
			res0_q.target_id <= cur_q.interval_id;
			res0_q.last      <= !evict;
			res1_q.kind        <= KIND_EVICT;
			res1_q.target_id   <= tag_q[last_idx];
			res1_q.reg_num     <= 3'd0;
			res1_q.slot_offset <= slot_q;
			res1_q.last        <= 1'b1;
			if (spill && !evict) begin
				res0_q.kind        <= KIND_SPILL;
				res0_q.reg_num     <= 3'd0;
				res0_q.slot_offset <= slot_q;
			end else if (evict) begin
				res0_q.kind        <= KIND_ASSIGN;
				res0_q.reg_num     <= 3'(areg_q[last_idx]);
				res0_q.slot_offset <= '0;
				ins_reg_q          <= areg_q[last_idx];
			end else begin
				res0_q.kind        <= KIND_ASSIGN;
				res0_q.reg_num     <= 3'(fstk_q[top_idx]);
				res0_q.slot_offset <= '0;
				ins_reg_q          <= fstk_q[top_idx];
			end
		end
		if (cmd.insert) begin
			if (!keep[0]) begin
				end_q[0]  <= cur_q.interval_end;
				tag_q[0]  <= cur_q.interval_id;
				areg_q[0] <= ins_reg_q;
			end
			for (int i = 1; i < POOL_REGS; i++) begin
				if (!keep[i]) begin
					if (keep[i-1]) begin
						end_q[i]  <= cur_q.interval_end;
						tag_q[i]  <= cur_q.interval_id;
						areg_q[i] <= ins_reg_q;
					end else begin
						end_q[i]  <= end_q[i-1];
						tag_q[i]  <= tag_q[i-1];
						areg_q[i] <= areg_q[i-1];
					end
				end
			end
		end
		if (cmd.emit0) res_data_q <= res0_q;
		if (cmd.emit1) res_data_q <= res1_q;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_scan_register_allocator.sv =====
// Top level of the linear scan register allocator: APB registers, sequencer, datapath.
// Depends on lsra_pkg, lsra_ctrl and lsra_dp.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+--------------------------------
//  request  | req_valid, req_stall, req_data   | id, start, end, restart
//  result   | res_valid, res_stall, res_data   | kind, target, reg, slot, last
//  config   | psel, penable, pwrite, paddr ... | max_active @0, stack_base @4
//
// With the output free, a request runs the expiry loop (one free-stack push per cycle
// for each interval it expires), then the decision, then the insertion if it gets a
// register, free or taken from an evicted interval, and then the loading of its result;
// an eviction then loads a second result for the victim. The next request is taken
// in the cycle after the last result is loaded; a stalled output holds the emit states.
// Reset empties the active set, fills the free stack and clears the slot counter.
`default_nettype none

module linear_scan_register_allocator import lsra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req_data,
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res_data
);

	localparam logic REG_MAX_ACTIVE = 1'b0;
	localparam logic REG_STACK_BASE = 1'b1;

	logic [3:0]  max_active_q;
	logic [15:0] stack_base_q;
	lsra_cmd_t   cmd;
	lsra_stat_t  stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= 4'd4;
			stack_base_q <= 16'd0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_MAX_ACTIVE: max_active_q <= pwdata[3:0];
				REG_STACK_BASE: stack_base_q <= pwdata[15:0];
				default:        max_active_q <= max_active_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_ACTIVE: prdata = {28'd0, max_active_q};
			REG_STACK_BASE: prdata = {16'd0, stack_base_q};
			default:        prdata = '0;
		endcase
	end

	lsra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lsra_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_active (max_active_q),
		.stack_base (stack_base_q),
		.req_data   (req_data),
		.cmd        (cmd),
		.stat       (stat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_scan_register_allocator.
// Depends on lsra_pkg and the allocator RTL; a scoreboard class predicts every allocation result.

module tb;
	import lsra_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 190;
	localparam int unsigned REG_MAX_ACTIVE = 0;
	localparam int unsigned REG_STACK_BASE = 1;

	class allocation_scoreboard;
		localparam int unsigned NREGS = 8;

		bit [3:0]  max_active;
		bit [15:0] stack_base;
		bit [15:0] act_end [NREGS];
		bit [9:0]  act_tag [NREGS];
		bit [2:0]  act_reg [NREGS];
		int unsigned act_n;
		bit [2:0]  free_regs [NREGS];
		int unsigned free_n;
		bit [15:0] slot_next;
		res_t      expected_allocs [$];
		int unsigned failures;

		function new();
			max_active = 4'd4;
			stack_base = 16'd0;
			failures = 0;
			clear_pool();
		endfunction

		function void clear_pool();
			act_n = 0;
			for (int i = 0; i < NREGS; i++)
				free_regs[i] = i[2:0];
			free_n = NREGS;
			slot_next = stack_base;
		endfunction

		function void set_register(int unsigned idx, bit [31:0] value);
			if (idx == REG_MAX_ACTIVE)
				max_active = value[3:0];
			else if (idx == REG_STACK_BASE)
				stack_base = value[15:0];
		endfunction

		// active list stays sorted by end; equal ends go after existing ones
		function void insert_active(bit [9:0] tag, bit [15:0] e, bit [2:0] rn);
			int unsigned pos;
			pos = 0;
			while (pos < act_n && act_end[pos] <= e)
				pos++;
			for (int unsigned i = act_n; i > pos; i--) begin
				act_end[i] = act_end[i-1];
				act_tag[i] = act_tag[i-1];
				act_reg[i] = act_reg[i-1];
			end
			act_end[pos] = e;
			act_tag[pos] = tag;
			act_reg[pos] = rn;
			act_n++;
		endfunction

		function void push_result(bit [1:0] k, bit [9:0] id, bit [2:0] rn, bit [15:0] slot,
				bit lst);
			res_t r;
			r.kind = k;
			r.target_id = id;
			r.reg_num = rn;
			r.slot_offset = slot;
			r.last = lst;
			expected_allocs = {expected_allocs, r};
		endfunction

		function void note_request(req_t q);
			int unsigned ex, lim;
			bit [15:0] slot;
			bit [9:0]  vtag;
			bit [2:0]  vreg;
			if (q.restart)
				clear_pool();
			ex = 0;
			while (ex < act_n && act_end[ex] < q.interval_start) begin
				if (free_n < NREGS) begin
					free_regs[free_n] = act_reg[ex];
					free_n++;
				end
				ex++;
			end
			for (int unsigned i = 0; i + ex < act_n; i++) begin
				act_end[i] = act_end[i+ex];
				act_tag[i] = act_tag[i+ex];
				act_reg[i] = act_reg[i+ex];
			end
			act_n -= ex;
			lim = max_active;
			if (lim < 1)
				lim = 1;
			if (lim > NREGS)
				lim = NREGS;
			if (act_n >= lim || free_n == 0) begin
				slot = slot_next;
				slot_next = slot_next + SLOT_STEP;
				if (act_n > 0 && act_end[act_n-1] > q.interval_end) begin
					vtag = act_tag[act_n-1];
					vreg = act_reg[act_n-1];
					act_n--;
					insert_active(q.interval_id, q.interval_end, vreg);
					push_result(KIND_ASSIGN, q.interval_id, vreg, 16'd0, 1'b0);
					push_result(KIND_EVICT, vtag, 3'd0, slot, 1'b1);
				end else begin
					push_result(KIND_SPILL, q.interval_id, 3'd0, slot, 1'b1);
				end
			end else begin
				free_n--;
				insert_active(q.interval_id, q.interval_end, free_regs[free_n]);
				push_result(KIND_ASSIGN, q.interval_id, free_regs[free_n], 16'd0, 1'b1);
			end
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("ERROR @%0t: %s", $time, msg);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_allocs.size() == 0) begin
				flag($sformatf("unexpected result kind=%0d id=%0d reg=%0d slot=%0d last=%0d",
					got.kind, got.target_id, got.reg_num, got.slot_offset, got.last));
				return;
			end
			want = expected_allocs.pop_front();
			if (got.kind !== want.kind || got.target_id !== want.target_id ||
					got.reg_num !== want.reg_num || got.slot_offset !== want.slot_offset ||
					got.last !== want.last)
				flag($sformatf({"result mismatch: expected kind=%0d id=%0d reg=%0d slot=%0d ",
					"last=%0d, got kind=%0d id=%0d reg=%0d slot=%0d last=%0d"},
					want.kind, want.target_id, want.reg_num, want.slot_offset, want.last,
					got.kind, got.target_id, got.reg_num, got.slot_offset, got.last));
		endfunction

		function int unsigned outstanding();
			return expected_allocs.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	req_t        req_data;
	logic        res_valid;
	logic        res_stall;
	res_t        res_data;

	allocation_scoreboard sb;
	bit          idle_off;
	bit          gaps_on;
	bit          stalls_on;
	int unsigned cycle_count;

	linear_scan_register_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
			sb.check_result(res_data);
	end

	// receiver back-pressure: bursts, with calm stretches in between
	initial begin
		res_stall = 1'b0;
		stalls_on = 1'b1;
		forever begin
			@(negedge clk);
			if (!idle_off && stalls_on && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				res_stall <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				stalls_on = !stalls_on;
			end
		end
	end

	function automatic req_t mk_req(int unsigned id, int unsigned s, int unsigned e, bit rst);
		req_t q;
		q.interval_id = id[9:0];
		q.interval_start = s[15:0];
		q.interval_end = e[15:0];
		q.restart = rst;
		return q;
	endfunction

	task automatic write_reg(int unsigned idx, bit [31:0] value);
		int unsigned addr;
		addr = idx * 4;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr[2:0];
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_request(req_t q);
		if (!idle_off && gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		if ($urandom_range(0, 59) == 0)
			gaps_on = !gaps_on;
		req_valid <= 1'b1;
		req_data <= q;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(q);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_phase(int unsigned count);
		int unsigned done, len, span, rnd;
		int unsigned pos, e;
		done = 0;
		// no restart and start 0: keeps the previous active set under the new limit
		repeat (3) begin
			offer_request(mk_req($urandom, 0, $urandom, 1'b0));
			done++;
		end
		while (done < count) begin
			if ($urandom_range(0, 4) != 0) begin
				len = $urandom_range(3, 30);
				pos = ($urandom_range(0, 9) == 0) ? $urandom_range(65000, 65535)
					: $urandom_range(0, 60000);
				for (int unsigned k = 0; k < len && done < count; k++) begin
					pos = pos + $urandom_range(0, 4);
					if (pos > 65535)
						pos = 65535;
					span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
						: $urandom_range(0, 30);
					e = pos + span;
					if (e > 65535)
						e = 65535;
					rnd = $urandom_range(0, 7);
					offer_request(mk_req($urandom, pos, e, k == 0 && rnd != 0));
					done++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if (done < count) begin
						rnd = $urandom_range(0, 3);
						offer_request(mk_req($urandom, $urandom, $urandom, rnd == 0));
						done++;
					end
				end
			end
		end
	endtask

	bit [3:0] phase_limit [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6,
		4'd7, 4'd4};
	bit [15:0] phase_base [PHASES] = '{16'd100, 16'hFFF0, 16'hFFFC, 16'hFFFF, 16'd0,
		16'h8000, 16'd12, 16'h7FFE, 16'h1234, 16'hFFF8};

	initial begin
		sb = new();
		idle_off = 1'b0;
		gaps_on = 1'b1;
		cycle_count = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_MAX_ACTIVE, 32'd4);
		write_reg(REG_STACK_BASE, 32'd0);

		// limit 4: ties on end, eviction of the latest tie, self spill, bulk expiry
		offer_request(mk_req(0, 0, 10, 1'b1));
		offer_request(mk_req(1, 1, 10, 1'b0));
		offer_request(mk_req(2, 2, 20, 1'b0));
		offer_request(mk_req(3, 3, 20, 1'b0));
		offer_request(mk_req(4, 4, 15, 1'b0));
		offer_request(mk_req(5, 5, 30, 1'b0));
		offer_request(mk_req(6, 5, 20, 1'b0));
		offer_request(mk_req(7, 25, 26, 1'b0));
		offer_request(mk_req(1023, 65535, 65535, 1'b0));
		offer_request(mk_req(8, 65535, 0, 1'b0));
		offer_request(mk_req(9, 65535, 100, 1'b0));
		offer_request(mk_req(10, 65535, 65535, 1'b0));
		offer_request(mk_req(11, 0, 0, 1'b0));
		offer_request(mk_req(11'h2AA, 16'h5555, 16'hAAAA, 1'b1));
		offer_request(mk_req(11'h155, 16'hAAAA, 16'h5555, 1'b1));
		offer_request(mk_req(0, 0, 0, 1'b1));
		offer_request(mk_req(1023, 0, 65535, 1'b0));
		offer_request(mk_req(12, 0, 65535, 1'b0));
		offer_request(mk_req(13, 0, 65535, 1'b0));
		offer_request(mk_req(14, 0, 65535, 1'b0));
		offer_request(mk_req(15, 0, 1, 1'b0));
		offer_request(mk_req(16, 1, 2, 1'b0));
		wait_for_results();

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_reg(REG_MAX_ACTIVE, {28'd0, phase_limit[p]});
			write_reg(REG_STACK_BASE, {16'd0, phase_base[p]});
			if (p == PHASES - 1)
				idle_off = 1'b1;
			run_random_phase(PHASE_ITEMS);
			wait_for_results();
		end

		repeat (40) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("ERROR: %0d expected results never arrived", sb.outstanding());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lsra_pkg.sv
hw/rtl/lsra_ctrl.sv
hw/rtl/lsra_dp.sv
hw/rtl/linear_scan_register_allocator.sv
tb/tb.sv
